// File: rtl/pra_pkg.sv
package pra_pkg;

	localparam int CoordW    = 32;
	localparam int DiffW     = CoordW + 1;
	localparam int GainShift = 14;
	localparam int GuardBits = 16;
	// Guarded datapath width: offset * gain * CORDIC gain stays below 2^49.
	localparam int XW        = 51;
	localparam int ZW        = 33;
	localparam int RndW      = XW - GuardBits;
	localparam int SumW      = RndW + 1;
	localparam int ProdW     = XW + GainShift;
	localparam int TurnUnitW = 32;

	localparam logic signed [30:0] GainQ30 = 31'sd652032874;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [XW-1:0]     xval_t;
	typedef logic signed [ZW-1:0]     zval_t;

	// Data carried beside the rotation: base is the centre when rotating,
	// the point itself when the item passes through.
	typedef struct packed {
		logic   rot;
		coord_t base_x;
		coord_t base_y;
	} side_t;

	typedef struct packed {
		xval_t x;
		xval_t y;
		zval_t z;
	} vec_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [29:0] atan_step(input int unsigned idx);
		logic [29:0] r;
		case (idx)
			0:  r = 30'd536870912;
			1:  r = 30'd316933406;
			2:  r = 30'd167458907;
			3:  r = 30'd85004756;
			4:  r = 30'd42667331;
			5:  r = 30'd21354465;
			6:  r = 30'd10679838;
			7:  r = 30'd5340245;
			8:  r = 30'd2670163;
			9:  r = 30'd1335087;
			10: r = 30'd667544;
			11: r = 30'd333772;
			12: r = 30'd166886;
			13: r = 30'd83443;
			14: r = 30'd41722;
			15: r = 30'd20861;
			16: r = 30'd10430;
			17: r = 30'd5215;
			18: r = 30'd2608;
			19: r = 30'd1304;
			20: r = 30'd652;
			21: r = 30'd326;
			22: r = 30'd163;
			23: r = 30'd81;
			24: r = 30'd41;
			25: r = 30'd20;
			26: r = 30'd10;
			27: r = 30'd5;
			28: r = 30'd3;
			29: r = 30'd1;
			30: r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/pra_prep.sv
module pra_prep import pra_pkg::*; #(
	parameter int TURN_BITS = 24
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  coord_t centre_x,
	input  coord_t centre_y,
	input  coord_t point_x,
	input  coord_t point_y,
	input  coord_t turn_angle,
	input  logic   down_en,
	output logic   out_valid,
	output vec_t   out_vec,
	output side_t  out_side
);

	localparam int RemW   = TURN_BITS - 2;
	localparam int ZShift = TurnUnitW - TURN_BITS;

	logic signed [DiffW-1:0] dx_s1, dy_s1;
	logic [1:0]              quarter_s1, quarter_s2;
	zval_t                   z_s1, z_s2;
	side_t                   side_s1, side_s2, side_s3;
	logic                    v_s1, v_s2, v_s3;
	xval_t                   x_s2, y_s2;
	vec_t                    vec_s3;

	logic                    en1, en2, en3;
	logic                    rot_d;
	logic [RemW-1:0]         rem_d;
	logic signed [ProdW-1:0] prod_x, prod_y;
	xval_t                   rx_d, ry_d;

	assign en3 = !v_s3 || down_en;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	assign rot_d  = !turn_angle[CoordW-1] && (|turn_angle);
	assign rem_d  = turn_angle[RemW-1:0];
	assign prod_x = dx_s1 * GainQ30;
	assign prod_y = dy_s1 * GainQ30;

	// whole quarter turns: (x,y) -> (y,-x) per quarter
	always_comb begin
		case (quarter_s2)
			2'd0: begin
				rx_d = x_s2;
				ry_d = y_s2;
			end
			2'd1: begin
				rx_d = y_s2;
				ry_d = -x_s2;
			end
			2'd2: begin
				rx_d = -x_s2;
				ry_d = -y_s2;
			end
			default: begin
				rx_d = -y_s2;
				ry_d = x_s2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			dx_s1          <= $signed({point_x[CoordW-1], point_x})
				- $signed({centre_x[CoordW-1], centre_x});
			dy_s1          <= $signed({point_y[CoordW-1], point_y})
				- $signed({centre_y[CoordW-1], centre_y});
			quarter_s1     <= turn_angle[TURN_BITS-1 -: 2];
			z_s1           <= zval_t'(ZW'(0) - (ZW'(rem_d) << ZShift));
			side_s1.rot    <= rot_d;
			side_s1.base_x <= rot_d ? centre_x : point_x;
			side_s1.base_y <= rot_d ? centre_y : point_y;
		end
		if (en2 && v_s1) begin
			// floor shift by the gain's fraction bits less the guard bits
			x_s2       <= prod_x[GainShift +: XW];
			y_s2       <= prod_y[GainShift +: XW];
			quarter_s2 <= quarter_s1;
			z_s2       <= z_s1;
			side_s2    <= side_s1;
		end
		if (en3 && v_s2) begin
			vec_s3.x <= rx_d;
			vec_s3.y <= ry_d;
			vec_s3.z <= z_s2;
			side_s3  <= side_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_vec   = vec_s3;
	assign out_side  = side_s3;

endmodule

// File: rtl/pra_cell.sv
module pra_cell import pra_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_en,
	input  vec_t  in_vec,
	input  side_t in_side,
	input  logic  down_en,
	output logic  out_valid,
	output vec_t  out_vec,
	output side_t out_side
);

	logic  v_q;
	vec_t  vec_q;
	side_t side_q;
	xval_t xs, ys;
	zval_t step;
	vec_t  nxt;

	assign in_en = !v_q || down_en;
	assign xs    = in_vec.x >>> STAGE;
	assign ys    = in_vec.y >>> STAGE;
	assign step  = zval_t'(ZW'(atan_step(STAGE)));

	// rotate toward the residual angle's sign
	always_comb begin
		if (!in_vec.z[ZW-1]) begin
			nxt.x = in_vec.x - ys;
			nxt.y = in_vec.y + xs;
			nxt.z = in_vec.z - step;
		end else begin
			nxt.x = in_vec.x + ys;
			nxt.y = in_vec.y - xs;
			nxt.z = in_vec.z + step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_en && in_valid) begin
			vec_q  <= nxt;
			side_q <= in_side;
		end
	end

	assign out_valid = v_q;
	assign out_vec   = vec_q;
	assign out_side  = side_q;

endmodule

// File: rtl/pra_post.sv
module pra_post import pra_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_en,
	input  vec_t   in_vec,
	input  side_t  in_side,
	output logic   out_valid,
	input  logic   out_ready,
	output coord_t rot_x,
	output coord_t rot_y,
	output logic   saturated
);

	localparam int TopW = SumW - CoordW + 1;

	logic                   v_s1, out_valid_q;
	logic signed [RndW-1:0] rx_s1, ry_s1;
	side_t                  side_s1;
	coord_t                 rx_q, ry_q;
	logic                   sat_q;

	logic                   en_o;
	xval_t                  bx, by;
	logic signed [SumW-1:0] sx, sy;
	logic                   ovf_x, ovf_y;
	coord_t                 cx, cy;

	assign en_o  = !out_valid_q || out_ready;
	assign in_en = !v_s1 || en_o;

	// add half an LSB, then drop the guard bits
	assign bx = in_vec.x + xval_t'(XW'(1) << (GuardBits - 1));
	assign by = in_vec.y + xval_t'(XW'(1) << (GuardBits - 1));

	assign sx = $signed({rx_s1[RndW-1], rx_s1})
		+ $signed({{(SumW-CoordW){side_s1.base_x[CoordW-1]}}, side_s1.base_x});
	assign sy = $signed({ry_s1[RndW-1], ry_s1})
		+ $signed({{(SumW-CoordW){side_s1.base_y[CoordW-1]}}, side_s1.base_y});

	assign ovf_x = !((&sx[SumW-1 -: TopW]) || !(|sx[SumW-1 -: TopW]));
	assign ovf_y = !((&sy[SumW-1 -: TopW]) || !(|sy[SumW-1 -: TopW]));

	assign cx = ovf_x ? {sx[SumW-1], {(CoordW-1){!sx[SumW-1]}}} : sx[CoordW-1:0];
	assign cy = ovf_y ? {sy[SumW-1], {(CoordW-1){!sy[SumW-1]}}} : sy[CoordW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_en) v_s1 <= in_valid;
			if (en_o)  out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_en && in_valid) begin
			rx_s1   <= bx[XW-1:GuardBits];
			ry_s1   <= by[XW-1:GuardBits];
			side_s1 <= in_side;
		end
		if (en_o && v_s1) begin
			rx_q  <= side_s1.rot ? cx : side_s1.base_x;
			ry_q  <= side_s1.rot ? cy : side_s1.base_y;
			sat_q <= side_s1.rot && (ovf_x || ovf_y);
		end
	end

	assign out_valid = out_valid_q;
	assign rot_x     = rx_q;
	assign rot_y     = ry_q;
	assign saturated = sat_q;

endmodule

// File: rtl/point_rotate_about_origin.sv
// Rotates Q16.16 points clockwise about a centre, one per unstalled cycle.
//
// Input channel (in_valid/in_ready) carries centre, point and a turn angle
// with 2^TURN_BITS units per turn; a zero or negative angle passes the point
// through unchanged. Output channel (out_valid/out_ready) carries the rotated
// point, saturated to 32 bits, and a flag set when either coordinate clipped.
//
// The pipeline has three prep stages (offset, gain multiply, quarter-turn
// swap), one cell per CORDIC micro-rotation, then a rounding stage and the
// output register.
// Throughput is one item per cycle unless stalled; every stage is a register
// with its own valid bit, so the chain keeps accepting while output waits.
//
// When the receiver stalls, each stage holds only if the stage after it is
// full and held, so bubbles close up and in_ready drops only once the
// whole chain is full. Reset clears all valid bits; the chain is empty and
// ready as soon as arst_n rises.
module point_rotate_about_origin import pra_pkg::*; #(
	parameter int CORDIC_STAGES = 24,
	parameter int TURN_BITS     = 24
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  coord_t centre_x,
	input  coord_t centre_y,
	input  coord_t point_x,
	input  coord_t point_y,
	input  coord_t turn_angle,
	output logic   out_valid,
	input  logic   out_ready,
	output coord_t rot_x,
	output coord_t rot_y,
	output logic   saturated
);

	// Taps between neighbors: index 0 is the prep output, index i+1 the
	// output of cell i.
	logic  valid [CORDIC_STAGES+1];
	logic  en    [CORDIC_STAGES+1];
	vec_t  vec   [CORDIC_STAGES+1];
	side_t side  [CORDIC_STAGES+1];

	// Offset, gain compensation and whole quarter turns.
	pra_prep #(
		.TURN_BITS(TURN_BITS)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.centre_x  (centre_x),
		.centre_y  (centre_y),
		.point_x   (point_x),
		.point_y   (point_y),
		.turn_angle(turn_angle),
		.down_en   (en[0]),
		.out_valid (valid[0]),
		.out_vec   (vec[0]),
		.out_side  (side[0])
	);

	// One micro-rotation per cell; each advances when its successor can take.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		pra_cell #(
			.STAGE(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid[i]),
			.in_en    (en[i]),
			.in_vec   (vec[i]),
			.in_side  (side[i]),
			.down_en  (en[i+1]),
			.out_valid(valid[i+1]),
			.out_vec  (vec[i+1]),
			.out_side (side[i+1])
		);
	end

	// Round off guard bits, add back the centre, saturate, hold for output.
	pra_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid[CORDIC_STAGES]),
		.in_en    (en[CORDIC_STAGES]),
		.in_vec   (vec[CORDIC_STAGES]),
		.in_side  (side[CORDIC_STAGES]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rot_x    (rot_x),
		.rot_y    (rot_y),
		.saturated(saturated)
	);

endmodule
